// ----- hw/rtl/lzc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lzc_pkg;

	localparam int BYTE_W    = 8;
	localparam int MIN_MATCH = 3;
	localparam int GROUP_W   = 16;
	localparam logic [BYTE_W-1:0] MATCH_TAG = 8'h80;

	// control broadcast along the window row
	typedef struct packed {
		logic              shift;
		logic              load;
		logic              step;
		logic [BYTE_W-1:0] cmp;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lzc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lzc_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  lzc_pkg::cell_ctrl_t      ctrl,
	input  wire                      valid,
	input  wire [lzc_pkg::BYTE_W-1:0] byte_in,
	input  wire                      tok_in,
	output logic [lzc_pkg::BYTE_W-1:0] byte_q,
	output logic                     tok_q
);
	import lzc_pkg::*;

	logic hit;

	assign hit = (byte_q == ctrl.cmp);

	always_ff @(posedge clk) begin
		if (ctrl.shift)
			byte_q <= byte_in;
	end

	// a token marks a candidate match still alive; it walks towards cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctrl.load) begin
			tok_q <= valid & hit;
		end else if (ctrl.step) begin
			tok_q <= tok_in & hit;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lzc_group.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lzc_group #(
	parameter int GW = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [GW-1:0]         tok,
	output logic                  any_q,
	output logic [$clog2(GW)-1:0] hi_q
);
	import lzc_pkg::*;

	logic                  any_c;
	logic [$clog2(GW)-1:0] hi_c;

	// highest live cell wins: farthest distance
	always_comb begin
		any_c = 1'b0;
		hi_c  = '0;
		for (int i = 0; i < GW; i++) begin
			if (tok[i]) begin
				any_c = 1'b1;
				hi_c  = ($clog2(GW))'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			hi_q  <= '0;
		end else begin
			any_q <= any_c;
			hi_q  <= hi_c;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lz77_byte_compressor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// LZ77 byte compressor with a small sliding window. Bytes enter one per
// transfer into a lookahead of MAX_MATCH bytes; once it is full, or after the
// byte flagged by s_tlast until it drains, one coding decision is made. The
// history sits in a row of WINDOW_SIZE cells; a match search broadcasts one
// lookahead byte per step along the row while live candidates walk one cell
// per step. A decision runs a start state that loads the candidates, then for
// each search step a wait state for the registered group results and an
// evaluate state; the search ends on a mismatch or at the end of the
// lookahead. Then each output byte is held until the receiver takes it, and
// the consumed bytes move into the history one by one. A match of three or
// more bytes leaves as 0x80|(len-3) then the distance; otherwise a literal.
// Input is taken only while no decision is in progress. History is emptied
// after the last byte of a stream.
module lz77_byte_compressor #(
	parameter int WINDOW_SIZE = 255,
	parameter int MAX_MATCH   = 15
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] in_byte
	input  wire        s_tlast,   // end_of_stream
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // out_last
);
	import lzc_pkg::*;

	localparam int LW  = $clog2(MAX_MATCH + 1);
	localparam int LAI = $clog2(MAX_MATCH);
	localparam int HW  = $clog2(WINDOW_SIZE + 1);
	localparam int GHW = $clog2(GROUP_W);
	localparam int NG  = (WINDOW_SIZE + GROUP_W - 1) / GROUP_W;
	localparam int PADN = NG * GROUP_W;

	typedef enum logic [2:0] {IDLE, START, WAIT, EVAL, OUT1, OUT2, CONSUME} state_t;

	state_t state_q;
	logic [BYTE_W-1:0] la_q   [MAX_MATCH];
	logic [BYTE_W-1:0] scan_q [MAX_MATCH];
	logic [LW-1:0]     la_fill_q, k_q, best_len_q, take_q;
	logic [BYTE_W-1:0] best_dist_q, dist_q, out_q;
	logic [HW-1:0]     hist_fill_q;
	logic              eos_q, last_q, out_last_q, is_match_q;

	cell_ctrl_t        ctrl;
	logic [BYTE_W-1:0] hbyte [WINDOW_SIZE];
	logic [PADN-1:0]   tok;
	logic [NG-1:0]     g_any;
	logic [GHW-1:0]    g_hi [NG];

	logic              any_c;
	logic [BYTE_W:0]   hi_c;
	logic [LW-1:0]     kp1, fin_len;
	logic [BYTE_W-1:0] fin_dist;
	logic              cont;

	assign ctrl.shift = (state_q == CONSUME);
	assign ctrl.load  = (state_q == START);
	assign ctrl.step  = (state_q == EVAL) && cont;
	assign ctrl.cmp   = (state_q == START) ? la_q[0] : scan_q[0];

	for (genvar c = 0; c < WINDOW_SIZE; c++) begin : g_cell
		logic [BYTE_W-1:0] bin;
		logic              tin;
		if (c == 0) begin : g_first
			assign bin = la_q[0];
		end else begin : g_mid
			assign bin = hbyte[c-1];
		end
		if (c == WINDOW_SIZE - 1) begin : g_top
			assign tin = 1'b0;
		end else begin : g_below
			assign tin = tok[c+1];
		end
		lzc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.valid  (HW'(c) < hist_fill_q),
			.byte_in(bin),
			.tok_in (tin),
			.byte_q (hbyte[c]),
			.tok_q  (tok[c])
		);
	end

	if (PADN > WINDOW_SIZE) begin : g_pad
		assign tok[PADN-1:WINDOW_SIZE] = '0;
	end

	for (genvar g = 0; g < NG; g++) begin : g_grp
		lzc_group #(.GW(GROUP_W)) u_grp (
			.clk   (clk),
			.arst_n(arst_n),
			.tok   (tok[g*GROUP_W +: GROUP_W]),
			.any_q (g_any[g]),
			.hi_q  (g_hi[g])
		);
	end

	always_comb begin
		any_c = 1'b0;
		hi_c  = '0;
		for (int g = 0; g < NG; g++) begin
			if (g_any[g]) begin
				any_c = 1'b1;
				hi_c  = (BYTE_W+1)'(g * GROUP_W) + (BYTE_W+1)'(g_hi[g]);
			end
		end
	end

	assign kp1      = k_q + LW'(1);
	assign cont     = any_c && (kp1 < la_fill_q);
	assign fin_len  = any_c ? kp1 : best_len_q;
	assign fin_dist = any_c ? BYTE_W'(hi_c + (BYTE_W+1)'(kp1)) : best_dist_q;

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == OUT1) || (state_q == OUT2);
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (state_q == IDLE && s_tvalid)
			la_q[la_fill_q[LAI-1:0]] <= s_tdata;
		else if (state_q == CONSUME)
			for (int i = 0; i < MAX_MATCH - 1; i++)
				la_q[i] <= la_q[i+1];
		if (state_q == START) begin
			for (int i = 0; i < MAX_MATCH - 1; i++)
				scan_q[i] <= la_q[i+1];
		end else if (ctrl.step) begin
			for (int i = 0; i < MAX_MATCH - 1; i++)
				scan_q[i] <= scan_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			la_fill_q   <= '0;
			hist_fill_q <= '0;
			k_q         <= '0;
			best_len_q  <= '0;
			best_dist_q <= '0;
			take_q      <= '0;
			dist_q      <= '0;
			out_q       <= '0;
			eos_q       <= 1'b0;
			last_q      <= 1'b0;
			out_last_q  <= 1'b0;
			is_match_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						la_fill_q <= la_fill_q + LW'(1);
						eos_q     <= s_tlast;
						if (s_tlast || (la_fill_q + LW'(1) == LW'(MAX_MATCH)))
							state_q <= START;
					end
				end
				START: begin
					k_q        <= '0;
					best_len_q <= '0;
					state_q    <= WAIT;
				end
				WAIT: begin
					state_q <= EVAL;
				end
				EVAL: begin
					if (any_c) begin
						best_len_q  <= kp1;
						best_dist_q <= fin_dist;
					end
					if (cont) begin
						k_q     <= kp1;
						state_q <= WAIT;
					end else begin
						if (fin_len >= LW'(MIN_MATCH)) begin
							is_match_q <= 1'b1;
							out_q      <= MATCH_TAG | BYTE_W'(fin_len - LW'(MIN_MATCH));
							dist_q     <= fin_dist;
							take_q     <= fin_len;
							out_last_q <= 1'b0;
							last_q     <= eos_q && (la_fill_q == fin_len);
						end else begin
							is_match_q <= 1'b0;
							out_q      <= la_q[0];
							take_q     <= LW'(1);
							out_last_q <= eos_q && (la_fill_q == LW'(1));
						end
						state_q <= OUT1;
					end
				end
				OUT1: begin
					if (m_tready) begin
						if (is_match_q) begin
							out_q      <= dist_q;
							out_last_q <= last_q;
							state_q    <= OUT2;
						end else begin
							state_q <= CONSUME;
						end
					end
				end
				OUT2: begin
					if (m_tready)
						state_q <= CONSUME;
				end
				CONSUME: begin
					// move the front lookahead byte into the history row
					la_fill_q <= la_fill_q - LW'(1);
					take_q    <= take_q - LW'(1);
					if (hist_fill_q != HW'(WINDOW_SIZE))
						hist_fill_q <= hist_fill_q + HW'(1);
					if (take_q == LW'(1)) begin
						if (!eos_q) begin
							state_q <= IDLE;
						end else if (la_fill_q != LW'(1)) begin
							state_q <= START;
						end else begin
							hist_fill_q <= '0;
							eos_q       <= 1'b0;
							state_q     <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
